// File: hw/rtl/assert_macros.svh
// assertion helpers for the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked implication check, held off during reset
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// stall check: once the guard holds, the expression is unchanged next cycle
`define CHK_STABLE(label, clk, rst_n, guard, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) guard |=> $stable(expr)) \
    else $error(msg);

`endif

// File: hw/rtl/dpsc_pkg.sv
package dpsc_pkg;

  localparam int EPOCH_W  = 64;
  localparam int GEN_W    = 64;
  localparam int OWNER_W  = 32;
  localparam int CMD_W    = 4;
  localparam int MODE_W   = 3;
  localparam int INFL_W   = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 64;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_OWNER_NUMBER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWNER_GEN    = 1'b1;

  // mode codes as seen on the result channel
  localparam logic [MODE_W-1:0] MODE_LEGACY    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REOPENING = 3'd1;
  localparam logic [MODE_W-1:0] MODE_READY     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_QUIESCING = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DRAINING  = 3'd4;

  typedef enum logic [4:0] {
    ST_LEGACY    = 5'b00001,
    ST_REOPENING = 5'b00010,
    ST_READY     = 5'b00100,
    ST_QUIESCING = 5'b01000,
    ST_DRAINING  = 5'b10000
  } mode_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_OBSERVE  = 4'd0,
    CMD_QUIESCE  = 4'd1,
    CMD_REOPEN   = 4'd2,
    CMD_READY    = 4'd3,
    CMD_FAILED   = 4'd4,
    CMD_FINISH   = 4'd5,
    CMD_PUBLISH  = 4'd6,
    CMD_FINISHED = 4'd7,
    CMD_ABORT    = 4'd8,
    CMD_QUERY    = 4'd9
  } cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [EPOCH_W-1:0] epoch;
    logic               mig;
    logic [GEN_W-1:0]   qgen;
    logic [OWNER_W-1:0] qowner;
  } evt_t;

  typedef struct packed {
    mode_t              mode;
    logic [EPOCH_W-1:0] seen_epoch;
    logic               epoch_valid;
    logic               migrating;
  } sess_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              started;
    logic              fast;
    logic              illegal;
  } res_t;

  function automatic logic [MODE_W-1:0] mode_code(mode_t m);
    logic [MODE_W-1:0] c;
    case (m)
      ST_LEGACY:    c = MODE_LEGACY;
      ST_REOPENING: c = MODE_REOPENING;
      ST_READY:     c = MODE_READY;
      ST_QUIESCING: c = MODE_QUIESCING;
      ST_DRAINING:  c = MODE_DRAINING;
      default:      c = MODE_LEGACY;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/dpsc_step.sv
// next session state and result for one event
module dpsc_step #(
  parameter int COUNT_BITS = 16
) (
  input  dpsc_pkg::evt_t                     evt,
  input  dpsc_pkg::sess_t                    cur,
  input  logic [COUNT_BITS-1:0]              batch,
  input  logic [dpsc_pkg::OWNER_W-1:0]       owner_number,
  input  logic [dpsc_pkg::GEN_W-1:0]         owner_gen,
  output dpsc_pkg::sess_t                    nxt,
  output logic [COUNT_BITS-1:0]              batch_nxt,
  output dpsc_pkg::res_t                     res
);

  logic changed;
  logic started;
  logic fast;
  logic bad;
  logic batch_zero;
  logic batch_one;
  logic batch_full;

  assign changed    = !cur.epoch_valid || (cur.seen_epoch != evt.epoch);
  assign batch_zero = (batch == '0);
  assign batch_one  = (batch == COUNT_BITS'(1));
  assign batch_full = (batch == '1);

  always_comb begin
    nxt       = cur;
    batch_nxt = batch;
    started   = 1'b0;
    fast      = 1'b0;
    bad       = 1'b0;
    case (dpsc_pkg::cmd_t'(evt.cmd))
      dpsc_pkg::CMD_OBSERVE: begin
        nxt.seen_epoch  = evt.epoch;
        nxt.epoch_valid = 1'b1;
        nxt.migrating   = evt.mig;
        if ((evt.mig || changed) && cur.mode == dpsc_pkg::ST_READY) begin
          nxt.mode = dpsc_pkg::ST_QUIESCING;
          started  = 1'b1;
        end
      end
      dpsc_pkg::CMD_QUIESCE: begin
        if (cur.mode == dpsc_pkg::ST_READY) begin
          nxt.mode = dpsc_pkg::ST_QUIESCING;
          started  = 1'b1;
        end
      end
      dpsc_pkg::CMD_REOPEN: begin
        if (cur.mode == dpsc_pkg::ST_LEGACY && !cur.migrating && batch_zero) begin
          nxt.mode = dpsc_pkg::ST_REOPENING;
        end else begin
          bad = 1'b1;
        end
      end
      dpsc_pkg::CMD_READY: begin
        if (cur.mode == dpsc_pkg::ST_REOPENING) begin
          nxt.mode = dpsc_pkg::ST_READY;
        end else begin
          bad = 1'b1;
        end
      end
      dpsc_pkg::CMD_FAILED: begin
        if (cur.mode == dpsc_pkg::ST_REOPENING) begin
          nxt.mode = dpsc_pkg::ST_LEGACY;
        end else begin
          bad = 1'b1;
        end
      end
      dpsc_pkg::CMD_FINISH: begin
        if (cur.mode == dpsc_pkg::ST_QUIESCING) begin
          nxt.mode = batch_zero ? dpsc_pkg::ST_LEGACY : dpsc_pkg::ST_DRAINING;
        end else begin
          bad = 1'b1;
        end
      end
      dpsc_pkg::CMD_PUBLISH: begin
        if (cur.mode == dpsc_pkg::ST_READY && !batch_full) begin
          batch_nxt = batch + COUNT_BITS'(1);
        end else begin
          bad = 1'b1;
        end
      end
      dpsc_pkg::CMD_FINISHED: begin
        if (!batch_zero) begin
          batch_nxt = batch - COUNT_BITS'(1);
          if (batch_one && cur.mode == dpsc_pkg::ST_DRAINING) begin
            nxt.mode = dpsc_pkg::ST_LEGACY;
          end
        end else begin
          bad = 1'b1;
        end
      end
      dpsc_pkg::CMD_ABORT: begin
        if (cur.mode != dpsc_pkg::ST_REOPENING) begin
          batch_nxt = '0;
          nxt.mode  = dpsc_pkg::ST_LEGACY;
        end else begin
          bad = 1'b1;
        end
      end
      dpsc_pkg::CMD_QUERY: begin
        if (evt.qowner != owner_number) begin
          bad = 1'b1;
        end else if (cur.mode == dpsc_pkg::ST_READY && !cur.migrating &&
                     evt.qgen == owner_gen && cur.epoch_valid &&
                     evt.epoch == cur.seen_epoch) begin
          fast = 1'b1;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase
  end

  assign res.mode    = dpsc_pkg::mode_code(nxt.mode);
  assign res.started = started;
  assign res.fast    = fast;
  assign res.illegal = bad;

endmodule

// File: hw/rtl/dual_path_session_controller_top.sv
// a request passes through the input register and then the result register before its
// result is offered on the result channel
// throughput: one request per cycle, limited only by the result register draining
// the session state updates as a request moves from the input register to the result register
// reset (rst_n low at a clock edge): legacy mode, zero batches, no epoch seen,
// no migration, owner number and generation zero, both stages empty
module dual_path_session_controller_top #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dpsc_pkg::CMD_W-1:0]          in_cmd,
  input  logic [dpsc_pkg::EPOCH_W-1:0]        in_epoch_value,
  input  logic                                in_migration_flag,
  input  logic [dpsc_pkg::GEN_W-1:0]          in_query_generation,
  input  logic [dpsc_pkg::OWNER_W-1:0]        in_query_owner,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dpsc_pkg::MODE_W-1:0]         out_mode,
  output logic                                out_quiesce_started,
  output logic                                out_use_fast_path,
  output logic [dpsc_pkg::INFL_W-1:0]         out_in_flight,
  output logic                                out_illegal,
  // config write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dpsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dpsc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // input stage
  logic                     s1_valid_r;
  logic                     s1_valid_nxt;
  dpsc_pkg::evt_t           s1_evt_r;

  // session state
  dpsc_pkg::sess_t          sess_r;
  dpsc_pkg::sess_t          sess_nxt;
  logic [COUNT_BITS-1:0]    batch_r;
  logic [COUNT_BITS-1:0]    batch_nxt;

  // config registers
  logic [dpsc_pkg::OWNER_W-1:0] owner_number_r;
  logic [dpsc_pkg::OWNER_W-1:0] owner_number_nxt;
  logic [dpsc_pkg::GEN_W-1:0]   owner_gen_r;
  logic [dpsc_pkg::GEN_W-1:0]   owner_gen_nxt;

  // result stage
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  dpsc_pkg::res_t           step_res;
  dpsc_pkg::res_t           out_res_r;
  logic [dpsc_pkg::INFL_W-1:0] out_infl_r;

  logic in_acc;
  logic s1_adv;
  logic cfg_acc;

  // the input register moves on whenever the result register is empty or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // config writes are always taken; software must write only while the block is idle, the block does not enforce it
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  dpsc_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .evt          (s1_evt_r),
    .cur          (sess_r),
    .batch        (batch_r),
    .owner_number (owner_number_r),
    .owner_gen    (owner_gen_r),
    .nxt          (sess_nxt),
    .batch_nxt    (batch_nxt),
    .res          (step_res)
  );

  // handshake bookkeeping
  always_comb begin
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // config register writes; generation only changes in legacy mode with nothing in flight
  always_comb begin
    owner_number_nxt = owner_number_r;
    owner_gen_nxt    = owner_gen_r;
    if (cfg_acc) begin
      case (cfg_index)
        dpsc_pkg::CFG_OWNER_NUMBER: begin
          owner_number_nxt = cfg_data[dpsc_pkg::OWNER_W-1:0];
        end
        dpsc_pkg::CFG_OWNER_GEN: begin
          if (sess_r.mode == dpsc_pkg::ST_LEGACY && batch_r == '0) begin
            owner_gen_nxt = cfg_data[dpsc_pkg::GEN_W-1:0];
          end
        end
        default: begin
          owner_number_nxt = owner_number_r;
        end
      endcase
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
      sess_r.mode         <= dpsc_pkg::ST_LEGACY;
      sess_r.seen_epoch   <= '0;
      sess_r.epoch_valid  <= 1'b0;
      sess_r.migrating    <= 1'b0;
      batch_r             <= '0;
      owner_number_r      <= '0;
      owner_gen_r         <= '0;
    end else begin
      s1_valid_r     <= s1_valid_nxt;
      out_valid_r    <= out_valid_nxt;
      owner_number_r <= owner_number_nxt;
      owner_gen_r    <= owner_gen_nxt;
      if (s1_adv) begin
        sess_r  <= sess_nxt;
        batch_r <= batch_nxt;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_evt_r.cmd    <= in_cmd;
      s1_evt_r.epoch  <= in_epoch_value;
      s1_evt_r.mig    <= in_migration_flag;
      s1_evt_r.qgen   <= in_query_generation;
      s1_evt_r.qowner <= in_query_owner;
    end
    if (s1_adv) begin
      out_res_r  <= step_res;
      // low bits of the counter, zero-extended when the counter is narrow
      out_infl_r <= dpsc_pkg::INFL_W'(batch_nxt);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_mode            = out_res_r.mode;
  assign out_quiesce_started = out_res_r.started;
  assign out_use_fast_path   = out_res_r.fast;
  assign out_in_flight       = out_infl_r;
  assign out_illegal         = out_res_r.illegal;

endmodule

// File: hw/rtl/dpsc_checker.sv
`include "assert_macros.svh"

module dpsc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [dpsc_pkg::MODE_W-1:0]        out_mode,
  input logic                               out_quiesce_started,
  input logic                               out_use_fast_path,
  input logic [dpsc_pkg::INFL_W-1:0]        out_in_flight,
  input logic                               out_illegal
);

  // a stalled result stays valid and keeps its in-flight count
  `CHK_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `CHK_STABLE(a_out_stable, clk, rst_n, out_valid && !out_ready, out_in_flight, "in_flight changed while stalled")

  // fast path only from a ready session on a legal query
  `CHK_ASSERT(a_fast_ready, clk, rst_n, out_valid && out_use_fast_path |-> out_mode == dpsc_pkg::MODE_READY && !out_illegal && !out_quiesce_started, "fast path outside ready mode")

  // legacy mode never carries batches
  `CHK_ASSERT(a_legacy_empty, clk, rst_n, out_valid && out_mode == dpsc_pkg::MODE_LEGACY |-> out_in_flight == '0, "batches in flight in legacy mode")

  // a quiesce start always lands in quiescing
  `CHK_ASSERT(a_qs_mode, clk, rst_n, out_valid && out_quiesce_started |-> out_mode == dpsc_pkg::MODE_QUIESCING && !out_illegal, "quiesce start without quiescing mode")

endmodule

bind dual_path_session_controller_top dpsc_checker u_dpsc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_mode            (out_mode),
  .out_quiesce_started (out_quiesce_started),
  .out_use_fast_path   (out_use_fast_path),
  .out_in_flight       (out_in_flight),
  .out_illegal         (out_illegal)
);
